// File: rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge of clk, off while rst_n is low
`define ASSERT_PROP(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// when pre holds, post must hold in the following cycle
`define ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

// File: rtl/utf8d_pkg.sv
// types and constants of the utf-8 stream decoder
`default_nettype none

package utf8d_pkg;

  localparam int unsigned CP_W  = 16;
  localparam int unsigned PART_W = 10;
  localparam logic [CP_W-1:0] QMARK = 16'h003F;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_TABLE = 2'd1,
    ERR_ENDED = 2'd2
  } err_t;

  typedef enum logic [2:0] {
    CLS_TERM,
    CLS_ASCII,
    CLS_LEAD2,
    CLS_LEAD3,
    CLS_OTHER
  } byte_class_t;

  // one classified byte as it travels through the queue
  typedef struct packed {
    byte_class_t cls;
    logic [6:0]  bits;
  } item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_NEED1,
    ST_NEED2,
    ST_HALT
  } dec_state_t;

endpackage

`default_nettype wire

// File: rtl/utf8_bmp_stream_decoder.sv
// utf-8 stream decoder (basic multilingual plane): top level
//
// input channel: one byte word per push, accepted when push is high and full
// is low; a zero byte ends the string. result channel: a word is waiting while
// empty is low and is taken with pop. each result carries a code point, an
// error code and an end-of-string flag. lead bytes, the middle byte of a
// three-byte sequence and bytes after a bad lead byte give no result;
// completed characters, the bad lead byte itself and every terminator give one.
// a pushed byte is classified by the front end and written into the queue;
// the back end then decodes it into the result register. throughput: one
// byte per cycle while the result register is empty or popped, set by the
// back end taking one queued word per cycle.
// when pop is held low the result register holds, the queue of DEPTH words
// fills and full rises; the front keeps accepting until then.
// reset clears the queue, the sequence state and the result valid flag;
// the block takes bytes in the first cycle after reset.
`default_nettype none

module utf8_bmp_stream_decoder #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  in_byte,
  output logic             empty,
  input  wire logic        pop,
  output logic [15:0]      out_code_point,
  output logic [1:0]       out_error_code,
  output logic             out_end_of_string
);
  import utf8d_pkg::*;

  item_t wr_item;
  item_t rd_item;
  logic  wr_en;
  logic  rd_en;
  logic  q_valid;
  logic  q_full;

  utf8d_front u_front (
    .push    (push),
    .in_byte (in_byte),
    .q_full  (q_full),
    .wr_item (wr_item),
    .wr_en   (wr_en)
  );

  utf8d_queue #(
    .DEPTH (DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_en),
    .wr_item (wr_item),
    .rd_en   (rd_en),
    .rd_item (rd_item),
    .q_valid (q_valid),
    .q_full  (q_full)
  );

  utf8d_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_item            (rd_item),
    .q_rd              (rd_en),
    .pop               (pop),
    .empty             (empty),
    .out_code_point    (out_code_point),
    .out_error_code    (out_error_code),
    .out_end_of_string (out_end_of_string)
  );

  assign full = q_full;

endmodule

`default_nettype wire

// File: rtl/utf8d_front.sv
// front end: takes bytes and classifies them by their lead bits
`default_nettype none

module utf8d_front (
  input  wire logic           push,
  input  wire logic [7:0]     in_byte,
  input  wire logic           q_full,
  output utf8d_pkg::item_t    wr_item,
  output logic                wr_en
);
  import utf8d_pkg::*;

  byte_class_t cls;

  always_comb begin
    if (in_byte == 8'h00) begin
      cls = CLS_TERM;
    end else if (in_byte[7] == 1'b0) begin
      cls = CLS_ASCII;
    end else if (in_byte[7:5] == 3'b110) begin
      cls = CLS_LEAD2;
    end else if (in_byte[7:4] == 4'b1110) begin
      cls = CLS_LEAD3;
    end else begin
      // continuation prefix (only valid inside a sequence) or longer lead
      cls = CLS_OTHER;
    end
  end

  assign wr_item.cls  = cls;
  assign wr_item.bits = in_byte[6:0];
  assign wr_en        = push && !q_full;

endmodule

`default_nettype wire

// File: rtl/utf8d_queue.sv
// short queue of classified bytes between front and back
`default_nettype none

module utf8d_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             wr_en,
  input  wire utf8d_pkg::item_t wr_item,
  input  wire logic             rd_en,
  output utf8d_pkg::item_t      rd_item,
  output logic                  q_valid,
  output logic                  q_full
);
  import utf8d_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  item_t         slot_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_wr, do_rd;

  assign q_valid = (count_r != '0);
  assign q_full  = (count_r == CW'(DEPTH));
  assign rd_item = slot_r[rd_ptr_r];
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && q_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + CW'(1);
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot_r[wr_ptr_r] <= wr_item;
    end
  end

endmodule

`default_nettype wire

// File: rtl/utf8d_back.sv
// back end: sequence state, value assembly and the result register
`default_nettype none

module utf8d_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             q_valid,
  input  wire utf8d_pkg::item_t q_item,
  output logic                  q_rd,
  input  wire logic             pop,
  output logic                  empty,
  output logic [15:0]           out_code_point,
  output logic [1:0]            out_error_code,
  output logic                  out_end_of_string
);
  import utf8d_pkg::*;

  dec_state_t        state_r, state_nxt;
  logic [PART_W-1:0] partial_r, partial_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [CP_W-1:0]   cp_r;
  err_t              err_r;
  logic              eos_r;

  logic              take;
  logic              emit;
  logic [CP_W-1:0]   emit_cp;
  err_t              emit_err;
  logic              emit_eos;

  // a word leaves the queue whenever the result register can hold its answer
  assign take = q_valid && (!out_valid_r || pop);
  assign q_rd = take;

  // next state
  always_comb begin
    state_nxt = state_r;
    if (take) begin
      if (q_item.cls == CLS_TERM) begin
        state_nxt = ST_IDLE;
      end else begin
        case (state_r)
          ST_IDLE: begin
            case (q_item.cls)
              CLS_LEAD2: state_nxt = ST_NEED1;
              CLS_LEAD3: state_nxt = ST_NEED2;
              CLS_OTHER: state_nxt = ST_HALT;
              default:   state_nxt = ST_IDLE;
            endcase
          end
          ST_NEED1: state_nxt = ST_IDLE;
          ST_NEED2: state_nxt = ST_NEED1;
          ST_HALT:  state_nxt = ST_HALT;
          default:  state_nxt = ST_IDLE;
        endcase
      end
    end
  end

  // outputs and value assembly
  always_comb begin
    partial_nxt = partial_r;
    emit        = 1'b0;
    emit_cp     = '0;
    emit_err    = ERR_NONE;
    emit_eos    = 1'b0;
    if (take) begin
      if (q_item.cls == CLS_TERM) begin
        partial_nxt = '0;
        emit        = 1'b1;
        emit_eos    = 1'b1;
        if (state_r == ST_NEED1 || state_r == ST_NEED2) begin
          emit_cp  = QMARK;
          emit_err = ERR_ENDED;
        end
      end else begin
        case (state_r)
          ST_IDLE: begin
            case (q_item.cls)
              CLS_ASCII: begin
                emit    = 1'b1;
                emit_cp = {9'd0, q_item.bits};
              end
              CLS_LEAD2: partial_nxt = {5'd0, q_item.bits[4:0]};
              CLS_LEAD3: partial_nxt = {6'd0, q_item.bits[3:0]};
              default: begin
                emit     = 1'b1;
                emit_cp  = QMARK;
                emit_err = ERR_TABLE;
              end
            endcase
          end
          ST_NEED1: begin
            emit        = 1'b1;
            emit_cp     = {partial_r, q_item.bits[5:0]};
            partial_nxt = '0;
          end
          ST_NEED2: partial_nxt = {partial_r[3:0], q_item.bits[5:0]};
          default: begin
            // halted: byte dropped until the terminator
            emit = 1'b0;
          end
        endcase
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (take && emit) begin
      out_valid_nxt = 1'b1;
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      partial_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      partial_r   <= partial_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      cp_r  <= emit_cp;
      err_r <= emit_err;
      eos_r <= emit_eos;
    end
  end

  assign empty             = !out_valid_r;
  assign out_code_point    = cp_r;
  assign out_error_code    = err_r;
  assign out_end_of_string = eos_r;

endmodule

`default_nettype wire

// File: rtl/utf8d_checker.sv
// port-level checker for the utf-8 stream decoder and its bind
`default_nettype none
`include "assert_macros.svh"

module utf8d_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        full,
  input wire logic        empty,
  input wire logic        pop,
  input wire logic [15:0] out_code_point,
  input wire logic [1:0]  out_error_code,
  input wire logic        out_end_of_string
);
  import utf8d_pkg::*;

  // a string cut short is only reported at its terminator
  `ASSERT_PROP(a_ended_at_eos, !empty && out_error_code == ERR_ENDED |-> out_end_of_string, "stream-ended error without end of string")

  // every error word carries the replacement character
  `ASSERT_PROP(a_err_qmark, !empty && out_error_code != ERR_NONE |-> out_code_point == QMARK, "error word without replacement character")

  // a clean terminator answers with code point zero
  `ASSERT_PROP(a_eos_zero, !empty && out_end_of_string && out_error_code == ERR_NONE |-> out_code_point == '0, "clean terminator with nonzero code point")

  // right after reset nothing waits and the input side is open
  `ASSERT_PROP(a_reset_clear, !$past(rst_n) |-> empty && !full, "queue or result not clear after reset")

  // a word that is not popped stays
  `ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(out_code_point), "stalled word lost or changed")

endmodule

bind utf8_bmp_stream_decoder utf8d_checker u_utf8d_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .full              (full),
  .empty             (empty),
  .pop               (pop),
  .out_code_point    (out_code_point),
  .out_error_code    (out_error_code),
  .out_end_of_string (out_end_of_string)
);

`default_nettype wire
